// ===== src/ray_sphere_intersect_assert.svh =====
// Assertion macros for the ray/sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rsi_pkg.sv =====
`default_nettype none
package rsi_pkg;

  localparam int CW = 32;
  localparam int FB = 16;

  function automatic int rsi_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int PW   = CW + 1;
  localparam int PDW  = PW + CW;
  localparam int VW   = PDW + 2;
  localparam int PSW  = 2 * PW;
  localparam int PLW  = PSW + 2;
  localparam int RW   = CW - 1;
  localparam int RRW  = 2 * RW;
  localparam int INW  = PLW + 1;
  localparam int VMW  = VW - 1;
  localparam int LW   = (VMW + 1) / 2;
  localparam int HW   = VMW - LW;
  localparam int VVW  = 2 * VMW;
  localparam int DW   = rsi_max(INW + 2 * FB, VVW + 1) + 1;
  localparam int SQW  = DW + (DW % 2);
  localparam int RTW  = SQW / 2;
  localparam int RMW  = RTW + 3;
  localparam int FW   = rsi_max(rsi_max(CW + FB, VW), RTW + 1) + 2;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] base;
    logic signed [FW-1:0] t0;
  } rsi_side_t;

endpackage
`default_nettype wire

// ===== src/rsi_sqrt.sv =====
`default_nettype none
module rsi_sqrt
  import rsi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [SQW-1:0]  in_rad,
  input  wire rsi_side_t       in_side,
  output logic                 out_vld,
  output logic [RTW-1:0]       out_root,
  output rsi_side_t            out_side
);

  // one root bit per stage, restoring digit recurrence
  logic [RMW-1:0] rem_r  [RTW];
  logic [RTW-1:0] root_r [RTW];
  logic [SQW-1:0] dsh_r  [RTW];
  rsi_side_t      side_r [RTW];
  logic           vld_r  [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RMW-1:0] rem_in;
    logic [RTW-1:0] root_in;
    logic [SQW-1:0] dsh_in;
    rsi_side_t      side_in;
    logic           vld_in;
    logic [RMW-1:0] pre;
    logic [RMW-1:0] trial;
    logic           ge;
    logic [RMW-1:0] rem_nxt;
    logic [RTW-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign dsh_in  = in_rad;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign dsh_in  = dsh_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign pre      = {rem_in[RMW-3:0], dsh_in[SQW-1:SQW-2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (pre >= trial);
    assign rem_nxt  = ge ? (pre - trial) : pre;
    assign root_nxt = {root_in[RTW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        dsh_r[k]  <= {dsh_in[SQW-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[RTW-1];
  assign out_root = root_r[RTW-1];
  assign out_side = side_r[RTW-1];

endmodule
`default_nettype wire

// ===== src/ray_sphere_intersect.sv =====
// Ray against sphere test, one ray per beat, no state between beats.
// Input channel: sphere centre, radius, ray origin, direction and base
// distance, all Q16.16, on in_valid / in_stall. Result channel: hit flag
// and distance on out_valid / out_stall. A beat is taken at a rising edge
// with valid high and stall low.
// The pipeline has, at the default widths, six arithmetic stages
// (offset, products, sums, split square of v, partial-product sum, d and
// base term), one stage per root bit of the square root (67 bits here),
// and the output register. It takes one beat per cycle unless stalled.
// The whole pipeline advances together: when out_valid is high and
// out_stall is asserted, every stage holds and in_stall is raised, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Synchronous active-low reset clears all valid bits; data registers are
// not reset. On a miss the distance is the base distance unchanged.
`default_nettype none
module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [CW-1:0] in_center_x,
  input  wire logic signed [CW-1:0] in_center_y,
  input  wire logic signed [CW-1:0] in_center_z,
  input  wire logic [RW-1:0]        in_sphere_radius,
  input  wire logic signed [CW-1:0] in_origin_x,
  input  wire logic signed [CW-1:0] in_origin_y,
  input  wire logic signed [CW-1:0] in_origin_z,
  input  wire logic signed [CW-1:0] in_dir_x,
  input  wire logic signed [CW-1:0] in_dir_y,
  input  wire logic signed [CW-1:0] in_dir_z,
  input  wire logic signed [CW-1:0] in_base_distance,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic signed [CW-1:0]      out_distance
);

  logic en;
  logic out_valid_r;
  logic [6:1] vld_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: offset P = C - O
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [CW-1:0] dx_r, dy_r, dz_r;
  logic [RW-1:0]        rad_r;
  logic signed [CW-1:0] b1_r;

  // stage 2: products
  logic signed [PDW-1:0] pdx_r, pdy_r, pdz_r;
  logic signed [PSW-1:0] ppx_r, ppy_r, ppz_r;
  logic [RRW-1:0]        rr_r;
  logic signed [CW-1:0]  b2_r;

  // stage 3: v and inside
  logic signed [VW-1:0]  v3_r;
  logic signed [INW-1:0] in3_r;
  logic signed [CW-1:0]  b3_r;

  // stage 4: split square of |v|
  logic [2*HW-1:0]       hh_r;
  logic [HW+LW-1:0]      hl_r;
  logic [2*LW-1:0]       ll_r;
  logic signed [VW-1:0]  v4_r;
  logic signed [INW-1:0] in4_r;
  logic signed [CW-1:0]  b4_r;

  // stage 5: v squared
  logic [VVW-1:0]        vv_r;
  logic signed [VW-1:0]  v5_r;
  logic signed [INW-1:0] in5_r;
  logic signed [CW-1:0]  b5_r;

  // stage 6: d, hit and base term
  logic [SQW-1:0] d6_r;
  rsi_side_t      side6_r;

  logic signed [PLW-1:0] plen_nxt;
  logic signed [VW-1:0]  av_nxt;
  logic [VMW-1:0]        avm_nxt;
  logic signed [DW-1:0]  d_nxt;
  logic signed [FW-1:0]  t0_nxt;

  assign plen_nxt = PLW'(ppx_r) + PLW'(ppy_r) + PLW'(ppz_r);
  assign av_nxt   = v3_r[VW-1] ? -v3_r : v3_r;
  assign avm_nxt  = av_nxt[VMW-1:0];
  assign d_nxt    = (DW'(in5_r) <<< (2 * FB)) + $signed({{(DW-VVW){1'b0}}, vv_r});
  assign t0_nxt   = (FW'(b5_r) <<< FB) + FW'(v5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= PW'(in_center_x) - PW'(in_origin_x);
      py_r  <= PW'(in_center_y) - PW'(in_origin_y);
      pz_r  <= PW'(in_center_z) - PW'(in_origin_z);
      dx_r  <= in_dir_x;
      dy_r  <= in_dir_y;
      dz_r  <= in_dir_z;
      rad_r <= in_sphere_radius;
      b1_r  <= in_base_distance;

      pdx_r <= PDW'(px_r) * PDW'(dx_r);
      pdy_r <= PDW'(py_r) * PDW'(dy_r);
      pdz_r <= PDW'(pz_r) * PDW'(dz_r);
      ppx_r <= PSW'(px_r) * PSW'(px_r);
      ppy_r <= PSW'(py_r) * PSW'(py_r);
      ppz_r <= PSW'(pz_r) * PSW'(pz_r);
      rr_r  <= RRW'(rad_r) * RRW'(rad_r);
      b2_r  <= b1_r;

      v3_r  <= VW'(pdx_r) + VW'(pdy_r) + VW'(pdz_r);
      in3_r <= $signed({{(INW-RRW){1'b0}}, rr_r}) - INW'(plen_nxt);
      b3_r  <= b2_r;

      hh_r  <= (2*HW)'(avm_nxt[VMW-1:LW]) * (2*HW)'(avm_nxt[VMW-1:LW]);
      hl_r  <= (HW+LW)'(avm_nxt[VMW-1:LW]) * (HW+LW)'(avm_nxt[LW-1:0]);
      ll_r  <= (2*LW)'(avm_nxt[LW-1:0]) * (2*LW)'(avm_nxt[LW-1:0]);
      v4_r  <= v3_r;
      in4_r <= in3_r;
      b4_r  <= b3_r;

      vv_r  <= (VVW'(hh_r) << (2 * LW)) + (VVW'(hl_r) << (LW + 1)) + VVW'(ll_r);
      v5_r  <= v4_r;
      in5_r <= in4_r;
      b5_r  <= b4_r;

      d6_r         <= SQW'(d_nxt);
      side6_r.hit  <= !(in5_r[INW-1] && d_nxt[DW-1]);
      side6_r.base <= b5_r;
      side6_r.t0   <= t0_nxt;
    end
  end

  logic           sq_vld;
  logic [RTW-1:0] sq_root;
  rsi_side_t      sq_side;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[6]),
    .in_rad   (d6_r),
    .in_side  (side6_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  logic signed [FW-1:0] diff;
  logic signed [FW-1:0] shr;
  logic                 ovf;
  logic signed [CW-1:0] sat;

  assign diff = sq_side.t0 - $signed({{(FW-RTW){1'b0}}, sq_root});
  assign shr  = diff >>> FB;
  assign ovf  = !((&shr[FW-1:CW-1]) || !(|shr[FW-1:CW-1]));
  assign sat  = ovf ? {shr[FW-1], {(CW-1){!shr[FW-1]}}} : shr[CW-1:0];

  logic                 out_hit_r;
  logic signed [CW-1:0] out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r      <= sq_side.hit;
      out_distance_r <= sq_side.hit ? sat : sq_side.base;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

endmodule
`default_nettype wire

// ===== src/rsi_checker.sv =====
`default_nettype none
`include "ray_sphere_intersect_assert.svh"
module rsi_checker
  import rsi_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_hit,
  input wire logic signed [CW-1:0] out_distance
);

  `RSI_ASSERT_NOW(a_rst_clear, $past(!rst_n), !out_valid, "result beat right after reset")
  `RSI_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input held without output stall")
  `RSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result beat dropped")
  `RSI_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_hit) && $stable(out_distance), "stalled result beat changed")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_hit      (out_hit),
  .out_distance (out_distance)
);
`default_nettype wire
